/* rtl/core/aob_pkg.sv */
// Shared types, constants and the sine table generator for the oscillator bank.
// No dependencies; every module of the bank but the checker aob_chk imports this package.
`default_nettype none
package aob_pkg;

    localparam logic signed [31:0] AMP_TINY = 32'sd107;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    // Configuration register indexes
    localparam logic [1:0] CFG_RAMP_GAIN = 2'd0;
    localparam logic [1:0] CFG_RAMP_LENGTH = 2'd1;
    localparam logic [1:0] CFG_PHASE_PER_HZ = 2'd2;

    localparam logic OP_NOTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic               vld;   // real slot, clear on the ring bubble
        logic               act;   // slot advanced on this tick (head stage only)
        logic [15:0]        id;
        logic signed [31:0] fnow;
        logic signed [31:0] fstep;
        logic signed [23:0] fgoal;
        logic signed [31:0] anow;
        logic signed [31:0] astep;
        logic signed [15:0] agoal;
        logic [31:0]        phase;
        logic [15:0]        rleft;
    } t_slot;

    typedef enum logic [1:0] {
        HM_PASS,
        HM_TICK,
        HM_APPLY
    } t_hmode;

    typedef struct packed {
        logic               shift;
        t_hmode             mode;
        logic               hit;
        logic               match;
        logic [15:0]        id;
        logic signed [23:0] freq;
        logic signed [15:0] amp;
    } t_head_ctl;

    typedef struct packed {
        logic [24:0] gain;
        logic [15:0] rlen;
        logic [23:0] pph;
    } t_cfg;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] amp;
        logic [31:0]        phase;
    } t_tap;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_TICK,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // One table entry, series evaluated in Q30 per quarter wave (elaboration only)
    function automatic logic signed [15:0] sine_entry(input int unsigned i,
                                                      input int unsigned tb);
        int unsigned       q;
        int unsigned       quad;
        int unsigned       j;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint unsigned   s;
        int                v;
        q = 32'd1 << (tb - 2);
        quad = (i >> (tb - 2)) & 32'd3;
        j = i & (q - 1);
        if ((quad & 32'd1) != 0) j = q - j;
        x = (64'(j) * HALF_PI_Q30) >> (tb - 2);
        x2 = (x * x) >> 30;
        t = ONE_Q30 - x2 / 110;
        t = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        v = int'((s + 64'd16384) >> 15);
        if (v > 32767) v = 32767;
        if (quad >= 2) v = -v;
        return 16'(v);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/additive_oscillator_bank_core.sv */
// Top level of the additive oscillator bank: control sequencer, slot ring, mixer.
// Depends on aob_pkg, aob_cell, aob_head and aob_mix.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-------------------------------
//  s (items) | in        | i_s_tvalid / o_s_tready   | tdata: partial_id, target_freq,
//            |           |                           |        target_amp; tuser: op
//  m (sample)| out       | o_m_tvalid / i_m_tready   | tdata: sample_out
//  cfg       | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Slots live in a ring of PARTIALS cells plus one head register (a bubble marks the
// gap), shifted once a cycle while a trip runs. A tick takes one trip, then waits for
// the mixer to drain and presents the sample. A note event takes two trips: one to
// search ids and silent slots, one to write the chosen slot. Reset is synchronous and
// clears all slots.
// One request is in work at a time; a tick waits at the end while the previous
// sample is still not taken. Configuration writes are taken in any cycle.
`default_nettype none
module additive_oscillator_bank_core
    import aob_pkg::*;
#(
    parameter int PARTIALS = 64,
    parameter int TABLE_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [55:0] i_s_tdata,   // [15:0] partial_id, [39:16] target_freq,
                                          // [55:40] target_amp
    input  wire logic        i_s_tuser,   // [0] op
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [23:0] sample_out
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [24:0] i_cfg_data
);

    localparam int IW = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
    localparam int CW = $clog2(PARTIALS + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt;
    logic [IW-1:0]   r_pick, r_mi, r_si, r_ptr;
    logic            r_fm, r_fs, r_match;
    logic [15:0]     r_id;
    logic signed [23:0] r_freq;
    logic signed [15:0] r_amp;
    t_cfg            r_cfg;
    logic            r_ovld;
    logic [23:0]     r_odata;

    logic            w_accept;
    logic            w_last;
    logic            w_shift;
    logic            w_clear;
    logic            w_busy;
    logic signed [23:0] w_sample;
    t_head_ctl       w_ctl;
    t_tap            w_tap;
    t_slot           w_slot [PARTIALS+1];

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_last = (r_cnt == CW'(PARTIALS));
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain <= 25'd17476;
            r_cfg.rlen <= 16'd960;
            r_cfg.pph <= 24'd89478;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RAMP_GAIN:    r_cfg.gain <= i_cfg_data;
                CFG_RAMP_LENGTH:  r_cfg.rlen <= i_cfg_data[15:0];
                CFG_PHASE_PER_HZ: r_cfg.pph <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = (i_s_tuser == OP_TICK) ? ST_TICK : ST_SCAN;
            end
            ST_SCAN:  if (w_last) n_state = ST_APPLY;
            ST_APPLY: if (w_last) n_state = ST_IDLE;
            ST_TICK:  if (w_last) n_state = ST_DRAIN;
            ST_DRAIN: if (!w_busy) n_state = ST_EMIT;
            ST_EMIT:  if (!r_ovld || i_m_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_shift = 1'b0;
        w_clear = 1'b0;
        w_ctl.mode = HM_PASS;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                w_clear = i_s_tvalid;
            end
            ST_SCAN: w_shift = 1'b1;
            ST_APPLY: begin
                w_shift = 1'b1;
                w_ctl.mode = HM_APPLY;
            end
            ST_TICK: begin
                w_shift = 1'b1;
                w_ctl.mode = HM_TICK;
            end
            default: begin
            end
        endcase
        w_ctl.shift = w_shift;
        w_ctl.hit = (r_cnt == CW'(r_pick));
        w_ctl.match = r_match;
        w_ctl.id = r_id;
        w_ctl.freq = r_freq;
        w_ctl.amp = r_amp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_ptr <= '0;
            r_fm <= 1'b0;
            r_fs <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_shift) r_cnt <= w_last ? '0 : r_cnt + CW'(1);
            if (w_accept) begin
                r_fm <= 1'b0;
                r_fs <= 1'b0;
            end
            // Search: the first hit in ring order is the lowest slot
            if (r_state == ST_SCAN && w_slot[PARTIALS].vld) begin
                if (!r_fm && w_slot[PARTIALS].id == r_id) r_fm <= 1'b1;
                if (!r_fs && w_slot[PARTIALS].anow == '0) r_fs <= 1'b1;
            end
            // Steal: advance the victim pointer when nothing matched and nothing was silent
            if (r_state == ST_SCAN && w_last && !r_fm && !r_fs) begin
                r_ptr <= (r_ptr == IW'(PARTIALS - 1)) ? '0 : r_ptr + IW'(1);
            end
            if (r_ovld && i_m_tready) r_ovld <= 1'b0;
            if (r_state == ST_EMIT && (!r_ovld || i_m_tready)) r_ovld <= 1'b1;
        end
    end

    // Request latch, search indexes and sample register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id <= i_s_tdata[15:0];
            r_freq <= i_s_tdata[39:16];
            r_amp <= i_s_tdata[55:40];
        end
        if (r_state == ST_SCAN && w_slot[PARTIALS].vld) begin
            if (!r_fm && w_slot[PARTIALS].id == r_id) r_mi <= r_cnt[IW-1:0];
            if (!r_fs && w_slot[PARTIALS].anow == '0) r_si <= r_cnt[IW-1:0];
        end
        if (r_state == ST_SCAN && w_last) begin
            r_match <= r_fm;
            r_pick <= r_fm ? r_mi : (r_fs ? r_si : r_ptr);
        end
        if (r_state == ST_EMIT && (!r_ovld || i_m_tready)) r_odata <= w_sample;
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata = r_odata;

    aob_head u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_cfg   (r_cfg),
        .i_slot  (w_slot[PARTIALS]),
        .o_slot  (w_slot[0]),
        .o_tap   (w_tap)
    );

    for (genvar k = 0; k < PARTIALS; k++) begin : g_ring
        aob_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_slot  (w_slot[k]),
            .o_slot  (w_slot[k+1])
        );
    end

    aob_mix #(
        .PARTIALS   (PARTIALS),
        .TABLE_BITS (TABLE_BITS)
    ) u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_clear),
        .i_tap    (w_tap),
        .o_busy   (w_busy),
        .o_sample (w_sample)
    );

endmodule
`default_nettype wire

/* rtl/core/aob_cell.sv */
// One storage cell of the slot ring: holds one slot and hands it on when the ring shifts.
// Depends on aob_pkg.
`default_nettype none
module aob_cell
    import aob_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_shift,
    input  wire t_slot i_slot,
    output t_slot      o_slot
);

    t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '{vld: 1'b1, default: '0};
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule
`default_nettype wire

/* rtl/core/aob_head.sv */
// Head stage of the slot ring: ramp/tick update, head register, phase advance.
// Depends on aob_pkg.
`default_nettype none
module aob_head
    import aob_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_head_ctl i_ctl,
    input  wire t_cfg      i_cfg,
    input  wire t_slot     i_slot,
    output t_slot          o_slot,
    output t_tap           o_tap
);

    t_slot r_a;
    t_slot n_a;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return s[31:0];
    endfunction

    // floor((goal - now) * gain / 2^24), gain split in two partial products
    function automatic logic signed [31:0] ramp(input logic signed [31:0] goal,
                                                input logic signed [31:0] now,
                                                input logic [24:0] g);
        logic signed [32:0] d;
        logic signed [46:0] ph;
        logic signed [45:0] pl;
        logic signed [59:0] tot;
        logic signed [59:0] sh;
        d = 33'(goal) - 33'(now);
        ph = d * $signed({1'b0, g[24:12]});
        pl = d * $signed({1'b0, g[11:0]});
        tot = (60'(ph) <<< 12) + 60'(pl);
        sh = tot >>> 24;
        if (sh[59:31] != '0 && sh[59:31] != '1)
            return sh[59] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return sh[31:0];
    endfunction

    // Update on the way into the head register
    always_comb begin
        logic signed [31:0] fgoal32;
        logic signed [31:0] agoal32;
        logic signed [31:0] anow_r;
        logic signed [31:0] fs;
        logic signed [31:0] as;
        n_a = i_slot;
        n_a.act = 1'b0;
        fgoal32 = {i_ctl.freq, 8'd0};
        agoal32 = {i_ctl.amp[15], i_ctl.amp, 15'd0};
        if (i_ctl.match) begin
            anow_r = (i_slot.anow == '0) ? AMP_TINY : i_slot.anow;
        end else begin
            anow_r = '0;
        end
        fs = ramp(fgoal32, i_slot.fnow, i_cfg.gain);
        as = ramp(agoal32, anow_r, i_cfg.gain);
        case (i_ctl.mode)
            HM_TICK: begin
                if (i_slot.vld && i_slot.anow != '0) begin
                    n_a.act = 1'b1;
                    if (i_slot.rleft != '0) begin
                        n_a.fnow = sat_add(i_slot.fnow, i_slot.fstep);
                        n_a.anow = sat_add(i_slot.anow, i_slot.astep);
                        n_a.rleft = i_slot.rleft - 16'd1;
                    end else begin
                        n_a.fnow = {i_slot.fgoal, 8'd0};
                        n_a.anow = {i_slot.agoal[15], i_slot.agoal, 15'd0};
                    end
                end
            end
            HM_APPLY: begin
                if (i_ctl.hit && i_slot.vld) begin
                    if (i_ctl.match) begin
                        n_a.fstep = fs;
                        n_a.anow = anow_r;
                    end else begin
                        n_a.id = i_ctl.id;
                        n_a.fnow = fgoal32;
                        n_a.fstep = '0;
                        n_a.anow = AMP_TINY;
                    end
                    n_a.astep = as;
                    n_a.fgoal = i_ctl.freq;
                    n_a.agoal = i_ctl.amp;
                    n_a.rleft = i_cfg.rlen;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
        end else if (i_ctl.shift) begin
            r_a <= n_a;
        end
    end

    // Phase advance on the way out of the head register
    always_comb begin
        logic signed [56:0] prod;
        prod = r_a.fnow * $signed({1'b0, i_cfg.pph});
        o_slot = r_a;
        o_slot.act = 1'b0;
        if (r_a.act) o_slot.phase = r_a.phase + prod[47:16];
        o_tap.vld = r_a.act && i_ctl.shift;
        o_tap.amp = r_a.anow;
        o_tap.phase = o_slot.phase;
    end

endmodule
`default_nettype wire

/* rtl/core/aob_mix.sv */
// Mixer pipeline: sine table read, amplitude product, running sum and output saturation.
// Depends on aob_pkg.
`default_nettype none
module aob_mix
    import aob_pkg::*;
#(
    parameter int PARTIALS = 64,
    parameter int TABLE_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_clear,
    input  wire t_tap        i_tap,
    output logic             o_busy,
    output logic signed [23:0] o_sample
);

    localparam int TSIZE = 1 << TABLE_BITS;
    localparam int SW = 49 + $clog2(PARTIALS);

    typedef logic signed [15:0] t_rom [TSIZE];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < TSIZE; i++) rom[i] = sine_entry(i, TABLE_BITS);
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic                   r_v1, r_v2, r_v3;
    logic signed [31:0]     r_amp1, r_amp2;
    logic [TABLE_BITS-1:0]  r_idx1;
    logic signed [15:0]     r_sin2;
    logic signed [47:0]     r_prod3;
    logic signed [SW-1:0]   r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_sum <= '0;
        end else begin
            r_v1 <= i_tap.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_clear) r_sum <= '0;
            else if (r_v3) r_sum <= r_sum + SW'(r_prod3);
        end
    end

    always_ff @(posedge i_clk) begin
        r_amp1 <= i_tap.amp;
        r_idx1 <= i_tap.phase[31 -: TABLE_BITS];
        r_amp2 <= r_amp1;
        r_sin2 <= SINE_ROM[r_idx1];
        r_prod3 <= r_amp2 * r_sin2;
    end

    assign o_busy = r_v1 || r_v2 || r_v3;

    // Floor by 2^22, saturate to 24 bits
    always_comb begin
        if (r_sum[SW-1:45] == '0 || r_sum[SW-1:45] == '1) o_sample = r_sum[45:22];
        else if (r_sum[SW-1]) o_sample = 24'sh800000;
        else o_sample = 24'sh7fffff;
    end

endmodule
`default_nettype wire

/* rtl/core/aob_chk.sv */
// Port-level checker for the oscillator bank, bound to the top level.
// Depends on additive_oscillator_bank_core's ports only.
`default_nettype none
module aob_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata
);

    // One request at a time: hold ready low right after a request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready held after accepted request");

    // A note event never starts a sample
    a_note_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser |=> !$rose(o_m_tvalid))
        else $error("sample raised by a note event");

    // A sample appears only at the end of work
    a_sample_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("sample appeared while idle");

    a_hold_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled sample changed");

endmodule

bind additive_oscillator_bank_core aob_chk u_aob_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire
